@@ rtl/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is high
`define ASRT_ON(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds across reset
`define ASRT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/atan2c_pkg.sv @@
`default_nettype none

package atan2c_pkg;

  // field widths
  localparam int ANGLE_W = 16;
  localparam int QUO_W   = 16;

  // ratio limits in q1.15
  localparam logic [QUO_W-1:0] RATIO_ONE = 16'd32768;
  localparam logic [QUO_W-1:0] RATIO_MAX = 16'd32767;

  // polynomial coefficients: cubic in q1.15, linear scaled to q45
  localparam int CUBE_W = 13;
  localparam logic [CUBE_W-1:0] COEF_CUBE = 13'd6432;
  localparam int R2_W   = 31;
  localparam int CPRD_W = CUBE_W + R2_W;
  localparam int POLY_W = 45;
  localparam logic [POLY_W-1:0] COEF_LIN_Q30 = 45'd32168 << 30;

  // split of the polynomial term for the final multiply
  localparam int PLO_W  = 22;
  localparam int PHI_W  = POLY_W - PLO_W;
  localparam int PHP_W  = PHI_W + QUO_W;
  localparam int PLP_W  = PLO_W + QUO_W;
  localparam int MAG_W  = 61;

  // q60 sum and base angles
  localparam int SUM_W = 63;
  localparam logic [SUM_W-1:0] BASE_QPI  = 63'h0C90FDAA22168C23;
  localparam logic [SUM_W-1:0] BASE_3QPI = 63'h25B2F8FE6643A469;
  localparam int SUM_FRAC = 60;

  // output saturation limits
  localparam int ANGLE_POS_MAX = 32767;
  localparam int ANGLE_NEG_MAX = 32768;

  // per request flags that travel beside the data
  typedef struct packed {
    logic xneg;
    logic yneg;
    logic zero;
    logic rneg;
  } info_t;

endpackage

`default_nettype wire

@@ rtl/atan2_cubic_approximation_top.sv @@
// throughput: one request per cycle while out_stall is low, set by the 18 stage pipeline with two
//   restoring divide steps in each of its eight divider stages
// reset: rst clears every stage valid bit so the pipeline comes up empty;
//   data registers are not reset
`default_nettype none

`include "assert_macros.svh"

module atan2_cubic_approximation_top
  import atan2c_pkg::*;
#(
  parameter int IN_WIDTH        = 16,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire signed [IN_WIDTH-1:0]  y_value,
  input  wire signed [IN_WIDTH-1:0]  x_value,
  output logic                       out_valid,
  input  wire                        out_stall,
  output logic signed [ANGLE_W-1:0]  angle
);

  // stage map
  localparam int STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES = QUO_W / STEPS_PER_STAGE;
  localparam int ST_PREP  = 0;
  localparam int ST_DIVIN = 1;
  localparam int ST_DIV0  = 2;
  localparam int ST_SQ    = ST_DIV0 + DIV_STAGES;
  localparam int ST_POLY  = ST_SQ + 1;
  localparam int ST_PART  = ST_POLY + 1;
  localparam int ST_MAG   = ST_PART + 1;
  localparam int ST_SUM   = ST_MAG + 1;
  localparam int ST_ABS   = ST_SUM + 1;
  localparam int ST_RND   = ST_ABS + 1;
  localparam int ST_OUT   = ST_RND + 1;
  localparam int NS       = ST_OUT + 1;

  localparam int NUM_W = IN_WIDTH + 15;
  localparam int SHIFT = SUM_FRAC - ANGLE_FRAC_BITS;
  localparam int RQ_W  = SUM_W - SHIFT;
  localparam int CMP_W = (RQ_W > 17) ? RQ_W : 17;
  localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (SHIFT - 1);

  logic [NS-1:0] v;
  logic [NS:0]   adv;
  info_t         info_s [ST_OUT];

  // stage advance: a stage loads when empty or when the next one moves
  assign adv[NS] = !out_stall;
  for (genvar i = 0; i < NS; i++) begin : g_adv
    assign adv[i] = !v[i] || adv[i+1];
  end

  assign in_stall  = !adv[0];
  assign out_valid = v[NS-1];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) v[i] <= v[i-1];
      end
    end
  end

  // fold the vector: numerator and denominator of the ratio
  logic [IN_WIDTH-1:0] ay_c;
  logic [IN_WIDTH+1:0] xe_c, aye_c, num_c, den_c;
  logic [IN_WIDTH:0]   prep_num, prep_den;

  always_comb begin
    ay_c  = y_value[IN_WIDTH-1] ? -y_value : y_value;
    xe_c  = {{2{x_value[IN_WIDTH-1]}}, x_value};
    aye_c = {2'b00, ay_c};
    if (x_value[IN_WIDTH-1]) begin
      num_c = xe_c + aye_c;
      den_c = aye_c - xe_c;
    end else begin
      num_c = xe_c - aye_c;
      den_c = xe_c + aye_c;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_PREP]) begin
      prep_num <= num_c[IN_WIDTH:0];
      prep_den <= den_c[IN_WIDTH:0];
    end
  end

  // divider operands: magnitude shifted up with half the divisor for rounding
  logic [IN_WIDTH:0]   div_rem [DIV_STAGES+1];
  logic [QUO_W-1:0]    div_low [DIV_STAGES+1];
  logic [QUO_W-1:0]    div_quo [DIV_STAGES+1];
  logic [IN_WIDTH:0]   div_den [DIV_STAGES+1];
  logic [IN_WIDTH:0]   num_neg_c;
  logic [IN_WIDTH-1:0] n_c;
  logic [NUM_W-1:0]    dvd_c;
  logic                zero_c;

  always_comb begin
    num_neg_c = -prep_num;
    n_c       = prep_num[IN_WIDTH] ? num_neg_c[IN_WIDTH-1:0] : prep_num[IN_WIDTH-1:0];
    dvd_c     = (NUM_W'(n_c) << 15) + NUM_W'(prep_den >> 1);
    zero_c    = (prep_den == '0);
  end

  always_ff @(posedge clk) begin
    if (adv[ST_DIVIN]) begin
      div_rem[0] <= (IN_WIDTH+1)'(dvd_c >> QUO_W);
      div_low[0] <= dvd_c[QUO_W-1:0];
      div_quo[0] <= '0;
      div_den[0] <= prep_den;
    end
  end

  // flags travel with the data
  always_ff @(posedge clk) begin
    if (adv[ST_PREP]) begin
      info_s[ST_PREP] <= '{xneg: x_value[IN_WIDTH-1], yneg: y_value[IN_WIDTH-1],
                           zero: 1'b0, rneg: 1'b0};
    end
    if (adv[ST_DIVIN]) begin
      info_s[ST_DIVIN] <= '{xneg: info_s[ST_PREP].xneg, yneg: info_s[ST_PREP].yneg,
                            zero: zero_c, rneg: prep_num[IN_WIDTH] || zero_c};
    end
    for (int i = ST_DIVIN + 1; i < ST_OUT; i++) begin
      if (adv[i]) info_s[i] <= info_s[i-1];
    end
  end

  // restoring divider, two quotient bits per stage
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [IN_WIDTH:0] rem_c;
    logic [QUO_W-1:0]  low_c, quo_c;

    always_comb begin
      logic [IN_WIDTH+1:0] trial;
      trial = '0;
      rem_c = div_rem[k];
      low_c = div_low[k];
      quo_c = div_quo[k];
      for (int s = 0; s < STEPS_PER_STAGE; s++) begin
        trial = {rem_c, low_c[QUO_W-1]};
        low_c = {low_c[QUO_W-2:0], 1'b0};
        if (trial >= {1'b0, div_den[k]}) begin
          trial = trial - {1'b0, div_den[k]};
          quo_c = {quo_c[QUO_W-2:0], 1'b1};
        end else begin
          quo_c = {quo_c[QUO_W-2:0], 1'b0};
        end
        rem_c = trial[IN_WIDTH:0];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[ST_DIV0+k]) begin
        div_rem[k+1] <= rem_c;
        div_low[k+1] <= low_c;
        div_quo[k+1] <= quo_c;
        div_den[k+1] <= div_den[k];
      end
    end
  end

  // ratio magnitude with saturation, then its square
  logic [QUO_W-1:0] ar_c;
  logic [QUO_W-1:0] sq_ar;
  logic [R2_W-1:0]  sq_r2;

  always_comb begin
    if (info_s[ST_SQ-1].zero) begin
      ar_c = RATIO_ONE;
    end else if (info_s[ST_SQ-1].rneg) begin
      ar_c = (div_quo[DIV_STAGES] > RATIO_ONE) ? RATIO_ONE : div_quo[DIV_STAGES];
    end else begin
      ar_c = (div_quo[DIV_STAGES] > RATIO_MAX) ? RATIO_MAX : div_quo[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_SQ]) begin
      sq_ar <= ar_c;
      sq_r2 <= R2_W'(ar_c) * R2_W'(ar_c);
    end
  end

  // linear coefficient minus cubic term, q45
  logic [CPRD_W-1:0] cube_c;
  logic [POLY_W-1:0] poly_p;
  logic [QUO_W-1:0]  poly_ar;

  assign cube_c = CPRD_W'(COEF_CUBE) * CPRD_W'(sq_r2);

  always_ff @(posedge clk) begin
    if (adv[ST_POLY]) begin
      poly_p  <= COEF_LIN_Q30 - POLY_W'(cube_c);
      poly_ar <= sq_ar;
    end
  end

  // polynomial times ratio as two partial products
  logic [PHP_W-1:0] part_hi;
  logic [PLP_W-1:0] part_lo;

  always_ff @(posedge clk) begin
    if (adv[ST_PART]) begin
      part_hi <= PHP_W'(poly_p[POLY_W-1:PLO_W]) * PHP_W'(poly_ar);
      part_lo <= PLP_W'(poly_p[PLO_W-1:0]) * PLP_W'(poly_ar);
    end
  end

  logic [MAG_W-1:0] mag;

  always_ff @(posedge clk) begin
    if (adv[ST_MAG]) begin
      mag <= (MAG_W'(part_hi) << PLO_W) + MAG_W'(part_lo);
    end
  end

  // add to or subtract from the base angle in q60
  logic [SUM_W-1:0] base_c;
  logic [SUM_W-1:0] sum;

  assign base_c = info_s[ST_SUM-1].xneg ? BASE_3QPI : BASE_QPI;

  always_ff @(posedge clk) begin
    if (adv[ST_SUM]) begin
      sum <= info_s[ST_SUM-1].rneg ? base_c + SUM_W'(mag) : base_c - SUM_W'(mag);
    end
  end

  // sign and magnitude of the sum
  logic [SUM_W-1:0] sum_neg_c;
  logic [SUM_W-2:0] abs_m;
  logic             abs_neg;

  assign sum_neg_c = -sum;

  always_ff @(posedge clk) begin
    if (adv[ST_ABS]) begin
      abs_neg <= sum[SUM_W-1];
      abs_m   <= sum[SUM_W-1] ? sum_neg_c[SUM_W-2:0] : sum[SUM_W-2:0];
    end
  end

  // round half away from zero to the angle fraction
  logic [SUM_W-1:0] rounded_c;
  logic [RQ_W-1:0]  rnd_q;
  logic             rnd_neg;

  assign rounded_c = {1'b0, abs_m} + HALF;

  always_ff @(posedge clk) begin
    if (adv[ST_RND]) begin
      rnd_q   <= rounded_c[SUM_W-1:SHIFT];
      rnd_neg <= abs_neg ^ info_s[ST_RND-1].yneg;
    end
  end

  // apply sign and saturate to the angle field
  logic [CMP_W-1:0] qx_c, sat_c;
  logic             neg_c;

  always_comb begin
    qx_c  = CMP_W'(rnd_q);
    neg_c = rnd_neg && (qx_c != '0);
    if (neg_c) begin
      sat_c = (qx_c > CMP_W'(ANGLE_NEG_MAX)) ? CMP_W'(ANGLE_NEG_MAX) : qx_c;
    end else begin
      sat_c = (qx_c > CMP_W'(ANGLE_POS_MAX)) ? CMP_W'(ANGLE_POS_MAX) : qx_c;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_OUT]) begin
      angle <= neg_c ? -(sat_c[ANGLE_W-1:0]) : sat_c[ANGLE_W-1:0];
    end
  end

  // checks
  `ASRT_ANY(a_empty_after_reset, rst |=> (v == '0), "pipeline not empty after reset")
  `ASRT_ON(a_stall_only_when_full, in_stall |-> (&v), "input stalled with a free stage")
  `ASRT_ON(a_quo_bound, (v[ST_SQ-1] && !info_s[ST_SQ-1].zero) |-> (div_quo[DIV_STAGES] <= RATIO_ONE), "ratio quotient above one")

endmodule

`default_nettype wire
